// ----- hdl/iept_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iept_pkg
// Shared types and constants for the input event to pointer translator.
// ----------------------------------------------------------------------------
package iept_pkg;

	localparam int unsigned AXIS_FULL = 32767;
	localparam logic [15:0] LEFT_BUTTON = 16'h0110;

	localparam logic [15:0] TYPE_SYNC = 16'd0;
	localparam logic [15:0] TYPE_KEY  = 16'd1;
	localparam logic [15:0] TYPE_ABS  = 16'd3;
	localparam logic [15:0] CODE_ABS_X = 16'd0;
	localparam logic [15:0] CODE_ABS_Y = 16'd1;
	localparam logic [15:0] CODE_SYNC_REPORT = 16'd0;

	localparam logic [1:0] KIND_MOVE   = 2'd0;
	localparam logic [1:0] KIND_BUTTON = 2'd1;
	localparam logic [1:0] KIND_KEY    = 2'd2;

	localparam logic [1:0] REG_TABLET_MODE   = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

	localparam logic [12:0] WIDTH_RESET  = 13'd1024;
	localparam logic [12:0] HEIGHT_RESET = 13'd768;

	typedef struct packed {
		logic [15:0] event_type;
		logic [15:0] event_code;
		logic [31:0] event_value;
	} event_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [28:0]        pointer_x_out;
		logic [28:0]        pointer_y_out;
		logic [15:0]        key_code;
		logic signed [31:0] event_level;
	} result_t;

	// decision made for one event, carried down the pipe
	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic        set_x;
		logic        set_y;
		logic [15:0] key_code;
		logic [31:0] level;
	} ctrl_t;

endpackage

// ----- hdl/input_event_to_pointer_translator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_to_pointer_translator_unit
// Turns device events into key, button and pointer move reports.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  dev       dev_valid / dev_stall  dev_item  (iept_pkg::event_t)
//  rpt       rpt_valid / rpt_stall  rpt_item  (iept_pkg::result_t)
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One event per cycle while reports are not stalled; a report leaves through the
// input register, multiply, fold and report register stages.
// The flags decide at the input register; the pointer commits in order when
// an event leaves the fold stage, so no event waits on another.
// Reset centres the pointer and clears the flags and every stage.
// A stalled report holds; earlier stages keep filling until the pipe is full.
// ----------------------------------------------------------------------------
module input_event_to_pointer_translator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dev_valid,
	output logic              dev_stall,
	input  iept_pkg::event_t  dev_item,
	output logic              rpt_valid,
	input  logic              rpt_stall,
	output iept_pkg::result_t rpt_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [12:0]       cfg_data
);

	logic        tablet_mode_q;
	logic [12:0] screen_width_q, screen_height_q;
	logic [28:0] pointer_x_q, pointer_y_q;

	logic             valid_s1, valid_s2, valid_s3;
	iept_pkg::event_t evt_s1;
	iept_pkg::ctrl_t  ctrl_s1, ctrl_s2, ctrl_s3;
	logic             rpt_valid_q;
	iept_pkg::result_t rpt_q, rpt_d;

	logic        out_free, mv1, mv2, mv3, rdy1, rdy2, rdy3;
	logic [28:0] quot, px, py;
	logic [12:0] size_sel;

	// handshake chain: a stage loads when empty or when it moves on
	assign out_free  = !rpt_valid_q || !rpt_stall;
	assign mv3       = valid_s3 && (!ctrl_s3.emit || out_free);
	assign rdy3      = !valid_s3 || mv3;
	assign mv2       = valid_s2 && rdy3;
	assign rdy2      = !valid_s2 || mv2;
	assign mv1       = valid_s1 && rdy2;
	assign rdy1      = !valid_s1 || mv1;
	assign dev_stall = !rdy1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tablet_mode_q   <= 1'b0;
			screen_width_q  <= iept_pkg::WIDTH_RESET;
			screen_height_q <= iept_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				iept_pkg::REG_TABLET_MODE:   tablet_mode_q   <= cfg_data[0];
				iept_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				iept_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	iept_event_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tablet_mode(tablet_mode_q),
		.evt        (evt_s1),
		.advance    (mv1),
		.ctrl       (ctrl_s1)
	);

	assign size_sel = ctrl_s1.set_y ? screen_height_q : screen_width_q;

	iept_axis_scale u_scale (
		.clk    (clk),
		.value  (evt_s1.event_value),
		.size   (size_sel),
		.load_s2(mv1),
		.load_s3(mv2),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= dev_valid;
			end
			if (rdy2) begin
				valid_s2 <= mv1;
			end
			if (rdy3) begin
				valid_s3 <= mv2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && dev_valid) begin
			evt_s1 <= dev_item;
		end
		if (mv1) begin
			ctrl_s2 <= ctrl_s1;
		end
		if (mv2) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	// bypass this event's own axis update into its report
	assign px = ctrl_s3.set_x ? quot : pointer_x_q;
	assign py = ctrl_s3.set_y ? quot : pointer_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_x_q <= 29'(iept_pkg::WIDTH_RESET >> 1);
			pointer_y_q <= 29'(iept_pkg::HEIGHT_RESET >> 1);
		end else if (mv3) begin
			pointer_x_q <= px;
			pointer_y_q <= py;
		end
	end

	always_comb begin
		rpt_d.result_kind = ctrl_s3.kind;
		rpt_d.key_code    = ctrl_s3.key_code;
		rpt_d.event_level = ctrl_s3.level;
		if (ctrl_s3.kind == iept_pkg::KIND_KEY) begin
			rpt_d.pointer_x_out = '0;
			rpt_d.pointer_y_out = '0;
		end else begin
			rpt_d.pointer_x_out = px;
			rpt_d.pointer_y_out = py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (mv3 && ctrl_s3.emit) begin
			rpt_valid_q <= 1'b1;
		end else if (!rpt_stall) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv3 && ctrl_s3.emit) begin
			rpt_q <= rpt_d;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt_item  = rpt_q;

	a_report_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(valid_s3 && ctrl_s3.emit))
		else $error("report raised without an emitting event in the last stage");

	a_report_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(mv3 && ctrl_s3.emit) |=> rpt_valid)
		else $error("emitting event retired but no report shown");

	a_pointer_x_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pointer_x_q) |-> $past(mv3 && ctrl_s3.set_x))
		else $error("pointer X changed without an X axis event retiring");

endmodule

// ----- hdl/iept_event_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iept_event_ctrl
// Decodes one event, keeps the fresh and pending flags, and decides the result.
// ----------------------------------------------------------------------------
module iept_event_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tablet_mode,
	input  iept_pkg::event_t evt,
	input  logic            advance,
	output iept_pkg::ctrl_t ctrl
);

	logic x_fresh_q, y_fresh_q, move_pending_q;
	logic x_fresh_d, y_fresh_d, move_pending_d;
	logic is_abs, is_sync, is_button, is_key;
	logic set_x, set_y, nx, ny, np;

	always_comb begin
		is_abs    = tablet_mode && (evt.event_type == iept_pkg::TYPE_ABS);
		is_sync   = tablet_mode && (evt.event_type == iept_pkg::TYPE_SYNC)
			&& (evt.event_code == iept_pkg::CODE_SYNC_REPORT);
		is_button = tablet_mode && (evt.event_type == iept_pkg::TYPE_KEY)
			&& (evt.event_code == iept_pkg::LEFT_BUTTON);
		is_key    = !tablet_mode && (evt.event_type == iept_pkg::TYPE_KEY);
		set_x     = is_abs && (evt.event_code == iept_pkg::CODE_ABS_X);
		set_y     = is_abs && (evt.event_code == iept_pkg::CODE_ABS_Y);
		nx        = x_fresh_q | set_x;
		ny        = y_fresh_q | set_y;
		np        = move_pending_q | set_x | set_y;

		x_fresh_d      = x_fresh_q;
		y_fresh_d      = y_fresh_q;
		move_pending_d = move_pending_q;

		ctrl.emit     = 1'b0;
		ctrl.kind     = iept_pkg::KIND_MOVE;
		ctrl.set_x    = set_x;
		ctrl.set_y    = set_y;
		ctrl.key_code = '0;
		ctrl.level    = '0;

		if (is_abs) begin
			if (nx && ny) begin
				// both axes in: flush the move if one is pending
				x_fresh_d      = 1'b0;
				y_fresh_d      = 1'b0;
				move_pending_d = 1'b0;
				ctrl.emit      = np;
			end else begin
				x_fresh_d      = nx;
				y_fresh_d      = ny;
				move_pending_d = np;
			end
		end else if (is_sync) begin
			x_fresh_d      = 1'b0;
			y_fresh_d      = 1'b0;
			move_pending_d = 1'b0;
			ctrl.emit      = move_pending_q;
		end else if (is_button) begin
			ctrl.emit  = 1'b1;
			ctrl.kind  = iept_pkg::KIND_BUTTON;
			ctrl.level = evt.event_value;
		end else if (is_key) begin
			ctrl.emit     = 1'b1;
			ctrl.kind     = iept_pkg::KIND_KEY;
			ctrl.key_code = evt.event_code;
			ctrl.level    = evt.event_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_fresh_q      <= 1'b0;
			y_fresh_q      <= 1'b0;
			move_pending_q <= 1'b0;
		end else if (advance) begin
			x_fresh_q      <= x_fresh_d;
			y_fresh_q      <= y_fresh_d;
			move_pending_q <= move_pending_d;
		end
	end

endmodule

// ----- hdl/iept_axis_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iept_axis_scale
// Scales an axis value to value*(size-1)/32767 over two register stages.
// ----------------------------------------------------------------------------
module iept_axis_scale (
	input  logic        clk,
	input  logic [31:0] value,
	input  logic [12:0] size,
	input  logic        load_s2,
	input  logic        load_s3,
	output logic [28:0] quot
);

	logic [12:0] factor;
	logic [44:0] product;
	logic [44:0] product_s2;
	logic [28:0] high_s3;
	logic [30:0] fold_s3;
	logic [15:0] high2;
	logic [16:0] rem_sum;
	logic [1:0]  corr;

	assign factor  = (size == 13'd0) ? 13'd0 : size - 13'd1;
	assign product = 45'(value) * 45'(factor);

	// x = h*2^15 + l = h*32767 + (h + l): fold twice, then fix up the tail
	always_ff @(posedge clk) begin
		if (load_s2) begin
			product_s2 <= product;
		end
		if (load_s3) begin
			high_s3 <= product_s2[43:15];
			fold_s3 <= 31'(product_s2[44:15]) + 31'(product_s2[14:0]);
		end
	end

	always_comb begin
		high2   = fold_s3[30:15];
		rem_sum = 17'(high2) + 17'(fold_s3[14:0]);
		if (rem_sum >= 17'(3 * iept_pkg::AXIS_FULL)) begin
			corr = 2'd3;
		end else if (rem_sum >= 17'(2 * iept_pkg::AXIS_FULL)) begin
			corr = 2'd2;
		end else if (rem_sum >= 17'(iept_pkg::AXIS_FULL)) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
		quot = high_s3 + 29'(high2) + 29'(corr);
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the input event to pointer translator. A directed
// table covers keyboard keys, tablet axis scaling at the size extremes,
// sync-driven moves, left-button reports and mode switches. Random phases
// follow under varying register settings. Every report is checked field by
// field against the table's expected report or an in-bench model of the translator.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 70;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 120;

	typedef struct {
		bit                is_write;
		iept_pkg::event_t  ev;
		logic [1:0]        reg_index;
		logic [12:0]       reg_value;
		bit                typed;
		bit                hit;
		iept_pkg::result_t want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              dev_valid;
	logic              dev_stall;
	iept_pkg::event_t  dev_item;
	logic              rpt_valid;
	logic              rpt_stall;
	iept_pkg::result_t rpt_item;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [12:0]       cfg_data;

	// translator state as the bench sees it
	bit          mode_tablet;
	logic [12:0] width_px;
	logic [12:0] height_px;
	logic [28:0] cur_x;
	logic [28:0] cur_y;
	bit          move_waiting;
	bit          x_new;
	bit          y_new;

	iept_pkg::result_t due_reports[$];
	iept_pkg::result_t want_rpt;
	plan_row_t plan[$];
	int        fail_count;
	int        events_sent;
	int        settings_seen;
	int        kind_count[3];
	int        hold_request;
	bit        idle_on;

	input_event_to_pointer_translator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.dev_valid (dev_valid),
		.dev_stall (dev_stall),
		.dev_item  (dev_item),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt_item  (rpt_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [28:0] axis_to_pixel(logic [31:0] raw, logic [12:0] size);
		logic [63:0] factor;
		logic [63:0] product;
		factor = 64'(size);
		if (size != 13'd0)
			factor = factor - 64'd1;
		product = (64'(raw) * factor) / 64'(iept_pkg::AXIS_FULL);
		return product[28:0];
	endfunction

	function automatic bit translate_event(input iept_pkg::event_t ev,
			output iept_pkg::result_t rpt);
		bit flush;
		flush = 1'b0;
		rpt = '0;
		if (mode_tablet && ev.event_type == iept_pkg::TYPE_ABS) begin
			if (ev.event_code == iept_pkg::CODE_ABS_X) begin
				cur_x = axis_to_pixel(ev.event_value, width_px);
				x_new = 1'b1;
				move_waiting = 1'b1;
			end else if (ev.event_code == iept_pkg::CODE_ABS_Y) begin
				cur_y = axis_to_pixel(ev.event_value, height_px);
				y_new = 1'b1;
				move_waiting = 1'b1;
			end
			flush = x_new && y_new;
		end else if (mode_tablet && ev.event_type == iept_pkg::TYPE_SYNC &&
				ev.event_code == iept_pkg::CODE_SYNC_REPORT) begin
			flush = 1'b1;
		end else if (mode_tablet && ev.event_type == iept_pkg::TYPE_KEY &&
				ev.event_code == iept_pkg::LEFT_BUTTON) begin
			rpt = '{iept_pkg::KIND_BUTTON, cur_x, cur_y, 16'd0, ev.event_value};
			return 1'b1;
		end else if (!mode_tablet && ev.event_type == iept_pkg::TYPE_KEY) begin
			rpt = '{iept_pkg::KIND_KEY, 29'd0, 29'd0, ev.event_code, ev.event_value};
			return 1'b1;
		end
		if (flush) begin
			x_new = 1'b0;
			y_new = 1'b0;
			if (move_waiting) begin
				move_waiting = 1'b0;
				rpt = '{iept_pkg::KIND_MOVE, cur_x, cur_y, 16'd0, 32'sd0};
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic iept_pkg::result_t report(logic [1:0] kind, logic [28:0] x,
			logic [28:0] y, logic [15:0] code, logic [31:0] level);
		return '{kind, x, y, code, level};
	endfunction

	function automatic plan_row_t row_pred(logic [15:0] t, logic [15:0] c, logic [31:0] v);
		plan_row_t r;
		r = '{1'b0, '{t, c, v}, 2'd0, 13'd0, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t row_none(logic [15:0] t, logic [15:0] c, logic [31:0] v);
		plan_row_t r;
		r = '{1'b0, '{t, c, v}, 2'd0, 13'd0, 1'b1, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t row_want(logic [15:0] t, logic [15:0] c, logic [31:0] v,
			iept_pkg::result_t want);
		plan_row_t r;
		r = '{1'b0, '{t, c, v}, 2'd0, 13'd0, 1'b1, 1'b1, want};
		return r;
	endfunction

	function automatic plan_row_t row_reg(logic [1:0] idx, logic [12:0] data);
		plan_row_t r;
		r = '{1'b1, '0, idx, data, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic logic [12:0] pick_size(int sel);
		case (sel)
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'd8191;
			4: return 13'($urandom_range(1, 4096));
			default: return 13'($urandom_range(0, 8191));
		endcase
	endfunction

	task automatic send_event(input iept_pkg::event_t ev, input bit typed, input bit hit,
			input iept_pkg::result_t want);
		iept_pkg::result_t got;
		bit has;
		dev_item  <= ev;
		dev_valid <= 1'b1;
		do @(posedge clk); while (dev_stall);
		events_sent++;
		has = translate_event(ev, got);
		if (typed) begin
			if (hit)
				due_reports.push_back(want);
		end else if (has) begin
			due_reports.push_back(got);
		end
	endtask

	task automatic pace_sender();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			dev_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// drain, let no-report events leave the pipe, then write one register
	task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
		dev_valid <= 1'b0;
		do @(posedge clk); while (due_reports.size() != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_seen++;
		case (idx)
			iept_pkg::REG_TABLET_MODE:   mode_tablet = data[0];
			iept_pkg::REG_SCREEN_WIDTH:  width_px = data;
			iept_pkg::REG_SCREEN_HEIGHT: height_px = data;
			default: ;
		endcase
	endtask

	// report side: random stall bursts, plus a long hold-off on request
	initial begin : rpt_side
		int n;
		rpt_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				rpt_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rpt_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rpt_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rpt_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rpt_valid && !rpt_stall) begin
			if (due_reports.size() == 0) begin
				$error("report with none due: kind %0d", rpt_item.result_kind);
				fail_count++;
			end else begin
				want_rpt = due_reports.pop_front();
				if (want_rpt.result_kind < 3)
					kind_count[want_rpt.result_kind]++;
				if (rpt_item.result_kind !== want_rpt.result_kind) begin
					$error("result_kind: expected %0d, got %0d",
						want_rpt.result_kind, rpt_item.result_kind);
					fail_count++;
				end
				if (rpt_item.pointer_x_out !== want_rpt.pointer_x_out) begin
					$error("pointer_x_out: expected %0d, got %0d",
						want_rpt.pointer_x_out, rpt_item.pointer_x_out);
					fail_count++;
				end
				if (rpt_item.pointer_y_out !== want_rpt.pointer_y_out) begin
					$error("pointer_y_out: expected %0d, got %0d",
						want_rpt.pointer_y_out, rpt_item.pointer_y_out);
					fail_count++;
				end
				if (rpt_item.key_code !== want_rpt.key_code) begin
					$error("key_code: expected 0x%04h, got 0x%04h",
						want_rpt.key_code, rpt_item.key_code);
					fail_count++;
				end
				if (rpt_item.event_level !== want_rpt.event_level) begin
					$error("event_level: expected %0d, got %0d",
						want_rpt.event_level, rpt_item.event_level);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin : stimulus
		iept_pkg::event_t ev;
		int     r;
		arst_n       = 1'b0;
		dev_valid    = 1'b0;
		dev_item     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = iept_pkg::REG_TABLET_MODE;
		cfg_data     = '0;
		hold_request = 0;
		idle_on      = 1'b1;
		fail_count   = 0;
		events_sent  = 0;
		settings_seen = 0;
		mode_tablet  = 1'b0;
		width_px     = iept_pkg::WIDTH_RESET;
		height_px    = iept_pkg::HEIGHT_RESET;
		cur_x        = 29'(iept_pkg::WIDTH_RESET / 2);
		cur_y        = 29'(iept_pkg::HEIGHT_RESET / 2);
		move_waiting = 1'b0;
		x_new        = 1'b0;
		y_new        = 1'b0;

		plan = '{
			row_want(iept_pkg::TYPE_KEY, 16'h001E, 32'd1,
				report(iept_pkg::KIND_KEY, 0, 0, 16'h001E, 32'd1)),
			row_want(iept_pkg::TYPE_KEY, 16'hFFFF, 32'hFFFF_FFFF,
				report(iept_pkg::KIND_KEY, 0, 0, 16'hFFFF, 32'hFFFF_FFFF)),
			row_want(iept_pkg::TYPE_KEY, 16'h0000, 32'h8000_0000,
				report(iept_pkg::KIND_KEY, 0, 0, 16'h0000, 32'h8000_0000)),
			row_want(iept_pkg::TYPE_KEY, iept_pkg::LEFT_BUTTON, 32'd0,
				report(iept_pkg::KIND_KEY, 0, 0, iept_pkg::LEFT_BUTTON, 32'd0)),
			row_none(iept_pkg::TYPE_SYNC, iept_pkg::CODE_SYNC_REPORT, 32'd0),
			row_none(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_X, 32'd32767),
			row_none(16'hFFFF, 16'hFFFF, 32'h5A5A_A5A5),
			row_reg(iept_pkg::REG_TABLET_MODE, 13'd1),
			// pointer still at the reset centre
			row_want(iept_pkg::TYPE_KEY, iept_pkg::LEFT_BUTTON, 32'd1,
				report(iept_pkg::KIND_BUTTON, 512, 384, 0, 32'd1)),
			row_none(iept_pkg::TYPE_SYNC, iept_pkg::CODE_SYNC_REPORT, 32'd0),
			row_none(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_X, 32'd32767),
			row_want(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_Y, 32'd0,
				report(iept_pkg::KIND_MOVE, 1023, 0, 0, 32'd0)),
			row_none(iept_pkg::TYPE_ABS, 16'h0002, 32'd100),
			row_pred(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_X, 32'hFFFF_FFFF),
			row_pred(iept_pkg::TYPE_SYNC, iept_pkg::CODE_SYNC_REPORT, 32'd0),
			row_pred(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_Y, 32'd16384),
			row_pred(iept_pkg::TYPE_SYNC, 16'h0001, 32'd0),
			row_pred(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_X, 32'd16384),
			row_pred(iept_pkg::TYPE_KEY, iept_pkg::LEFT_BUTTON, 32'hFFFF_FFFF),
			// zero width collapses X, oversize height wraps Y
			row_reg(iept_pkg::REG_SCREEN_WIDTH, 13'd0),
			row_reg(iept_pkg::REG_SCREEN_HEIGHT, 13'h1FFF),
			row_pred(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_X, 32'd32767),
			row_pred(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_Y, 32'hFFFF_FFFF),
			row_pred(iept_pkg::TYPE_ABS, iept_pkg::CODE_ABS_X, 32'd12345),
			// mode flip keeps the pending move
			row_reg(iept_pkg::REG_TABLET_MODE, 13'h1FFE),
			row_pred(iept_pkg::TYPE_SYNC, iept_pkg::CODE_SYNC_REPORT, 32'd0),
			row_pred(iept_pkg::TYPE_KEY, 16'h0042, 32'h7FFF_FFFF),
			row_reg(REG_UNUSED, 13'h1FFF),
			row_reg(iept_pkg::REG_TABLET_MODE, 13'h1FFF),
			row_pred(iept_pkg::TYPE_SYNC, iept_pkg::CODE_SYNC_REPORT, 32'd0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				write_reg(plan[i].reg_index, plan[i].reg_value);
			end else begin
				send_event(plan[i].ev, plan[i].typed, plan[i].hit, plan[i].want);
				pace_sender();
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			idle_on = (p != 3 && p != PHASES - 1);
			write_reg(iept_pkg::REG_TABLET_MODE, {12'($urandom), 1'(p != 1 && p != 5)});
			write_reg(iept_pkg::REG_SCREEN_WIDTH, pick_size(p % 6));
			write_reg(iept_pkg::REG_SCREEN_HEIGHT, pick_size((p + 4) % 6));
			if (p % 3 == 0)
				write_reg(REG_UNUSED, 13'($urandom));
			// hold the report side so the pipe backs up into the input
			if (p == 5)
				hold_request = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				ev.event_code  = iept_pkg::CODE_ABS_X;
				ev.event_value = ($urandom_range(0, 3) == 0) ? $urandom
					: 32'($urandom_range(0, 32767));
				if (mode_tablet) begin
					if (r < 30) begin
						ev.event_type = iept_pkg::TYPE_ABS;
					end else if (r < 60) begin
						ev.event_type = iept_pkg::TYPE_ABS;
						ev.event_code = iept_pkg::CODE_ABS_Y;
					end else if (r < 72) begin
						ev.event_type = iept_pkg::TYPE_SYNC;
						ev.event_code = iept_pkg::CODE_SYNC_REPORT;
					end else if (r < 82) begin
						ev.event_type = iept_pkg::TYPE_KEY;
						ev.event_code = iept_pkg::LEFT_BUTTON;
					end else if (r < 87) begin
						ev.event_type = iept_pkg::TYPE_KEY;
						ev.event_code = 16'($urandom_range(0, 65535));
					end else if (r < 92) begin
						ev.event_type = iept_pkg::TYPE_ABS;
						ev.event_code = 16'($urandom_range(2, 65535));
					end else begin
						ev.event_type = 16'($urandom_range(0, 65535));
						ev.event_code = 16'($urandom_range(0, 65535));
					end
				end else begin
					ev.event_type = iept_pkg::TYPE_KEY;
					ev.event_code = 16'($urandom_range(0, 65535));
					if (r >= 70 && r < 80)
						ev.event_type = iept_pkg::TYPE_SYNC;
					else if (r >= 80 && r < 85)
						ev.event_type = iept_pkg::TYPE_ABS;
					else if (r >= 85)
						ev.event_type = 16'($urandom_range(0, 65535));
				end
				send_event(ev, 1'b0, 1'b0, '0);
				if (p % 2 == 0 && n == PHASE_ITEMS / 2) begin
					// pause until every due report is back
					dev_valid <= 1'b0;
					do @(posedge clk); while (due_reports.size() != 0);
				end else if (!(p == 5 && n < 30)) begin
					pace_sender();
				end
			end
		end

		dev_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("run summary: %0d events, %0d moves, %0d buttons, %0d keys checked",
			events_sent, kind_count[iept_pkg::KIND_MOVE], kind_count[iept_pkg::KIND_BUTTON],
			kind_count[iept_pkg::KIND_KEY]);
		$display("run summary: %0d register writes, sizes 0 to 8191, long report hold-off",
			settings_seen);
		if (fail_count == 0 && due_reports.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
